@@ rtl/core/mte_pkg.sv @@
// Shared types and constants of the track event encoder.
`timescale 1ns / 1ps

package mte_pkg;

    localparam int PENDING_DEPTH = 10;
    localparam int COUNT_W       = 4;

    // Iterative divider geometry: a 41-bit dividend, a 26-bit divisor and a
    // 28-bit quotient formed four bits per cycle.
    localparam int NUM_W      = 41;
    localparam int DEN_W      = 26;
    localparam int QUO_W      = 28;
    localparam int DIV_STEPS  = 4;
    localparam int DIV_CYCLES = QUO_W / DIV_STEPS;
    localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

    localparam int TPQ_W   = 15;
    localparam int TICKS_W = 21;
    localparam int DUR_W   = 26;

    localparam logic [DEN_W-1:0]   USEC_PER_MINUTE = 26'd60000000;
    localparam logic [TICKS_W-1:0] MAX_TICKS       = 21'h1FFFFF;
    localparam logic [23:0]        MAX_TEMPO       = 24'hFFFFFF;

    localparam logic [9:0]       RESET_BPM       = 10'd120;
    localparam logic [7:0]       RESET_SIG_BEATS = 8'd4;
    localparam logic [7:0]       RESET_SIG_BASE  = 8'd4;
    localparam logic [DEN_W-1:0] RESET_USEC_PER_QUARTER =
        DEN_W'(USEC_PER_MINUTE / DEN_W'(RESET_BPM));

    localparam logic [3:0] NIB_NOTE_ON  = 4'h9;
    localparam logic [3:0] NIB_NOTE_OFF = 4'h8;
    localparam logic [7:0] BYTE_ZERO    = 8'h00;
    localparam logic [7:0] META_PREFIX  = 8'hFF;
    localparam logic [7:0] META_TEMPO   = 8'h51;
    localparam logic [7:0] META_TSIG    = 8'h58;
    localparam logic [7:0] META_EOT     = 8'h2F;
    localparam logic [7:0] LEN_TEMPO    = 8'h03;
    localparam logic [7:0] LEN_TSIG     = 8'h04;
    localparam logic [7:0] OFF_VELOCITY = 8'd64;
    localparam logic [7:0] CLOCKS_32ND  = 8'd8;

    typedef enum logic [1:0] {
        OP_NOTE  = 2'd0,
        OP_TEMPO = 2'd1,
        OP_TSIG  = 2'd2,
        OP_END   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        CFG_BPM       = 2'd0,
        CFG_SIG_BEATS = 2'd1,
        CFG_SIG_BASE  = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_TEMPO,
        F_DSTART,
        F_DWAIT,
        F_PUSH
    } front_state_t;

    // One encoded event: its bytes in order and how many are used.
    typedef struct packed {
        logic [PENDING_DEPTH-1:0][7:0] bytes;
        logic [COUNT_W-1:0]            count;
    } evt_t;

endpackage

@@ rtl/core/mte_div.sv @@
// Iterative radix-16 restoring divider with quotient overflow flag.
`timescale 1ns / 1ps

module mte_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [mte_pkg::NUM_W-1:0] num,
    input  logic [mte_pkg::DEN_W-1:0] den,
    output logic                      done,
    output logic                      ovf,
    output logic [mte_pkg::QUO_W-1:0] quo
);
    import mte_pkg::*;

    logic                 running_reg;
    logic                 done_reg;
    logic                 ovf_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DEN_W-1:0]     den_reg;
    logic [DEN_W-1:0]     rem_reg;
    logic [QUO_W-1:0]     qn_reg;
    logic [DEN_W-1:0]     rem_next;
    logic [QUO_W-1:0]     qn_next;

    // Dividend bits shift out of the top of qn_reg while quotient bits enter
    // at the bottom, so qn_reg ends up holding the quotient.
    always_comb begin
        logic [DEN_W:0] trial;
        logic           ge;
        rem_next = rem_reg;
        qn_next  = qn_reg;
        for (int i = 0; i < DIV_STEPS; i++) begin
            trial    = {rem_next, qn_next[QUO_W-1]};
            ge       = (trial >= {1'b0, den_reg});
            qn_next  = {qn_next[QUO_W-2:0], ge};
            rem_next = ge ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg <= 1'b0;
            done_reg    <= 1'b0;
            cnt_reg     <= '0;
        end else if (start) begin
            running_reg <= 1'b1;
            done_reg    <= 1'b0;
            cnt_reg     <= '0;
        end else if (running_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_CYCLES - 1)) begin
                running_reg <= 1'b0;
                done_reg    <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            den_reg <= den;
            rem_reg <= DEN_W'(num[NUM_W-1:QUO_W]);
            qn_reg  <= num[QUO_W-1:0];
            // A quotient that needs more than QUO_W bits is flagged up front.
            ovf_reg <= (DEN_W'(num[NUM_W-1:QUO_W]) >= den);
        end else if (running_reg) begin
            rem_reg <= rem_next;
            qn_reg  <= qn_next;
        end
    end

    assign done = done_reg;
    assign ovf  = ovf_reg;
    assign quo  = qn_reg;

endmodule

@@ rtl/core/mte_front.sv @@
// Front end: accepts events and configuration, divides, and builds byte lists.
`timescale 1ns / 1ps

module mte_front #(
    parameter int TICKS_PER_QUARTER = 240
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [1:0]                s_op,
    input  logic [3:0]                s_channel,
    input  logic [6:0]                s_key,
    input  logic [6:0]                s_velocity,
    input  logic [mte_pkg::DUR_W-1:0] s_duration_us,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [1:0]                cfg_index,
    input  logic [9:0]                cfg_data,
    output logic                      q_valid,
    input  logic                      q_ready,
    output mte_pkg::evt_t             q_evt
);
    import mte_pkg::*;

    localparam logic [TPQ_W-1:0] TPQ          = TPQ_W'(TICKS_PER_QUARTER);
    localparam logic [7:0]       CLICK_PLAIN  = 8'(TICKS_PER_QUARTER);
    localparam logic [7:0]       CLICK_TRIPLE = 8'(TICKS_PER_QUARTER / 3);

    front_state_t     state_reg;
    front_state_t     state_next;
    op_t              op_reg;
    logic [3:0]       channel_reg;
    logic [6:0]       key_reg;
    logic [6:0]       velocity_reg;
    logic [NUM_W-1:0] prod_reg;
    logic [DEN_W-1:0] upq_reg;
    logic [7:0]       sig_beats_reg;
    logic [7:0]       sig_base_reg;

    logic             div_start;
    logic [NUM_W-1:0] div_num;
    logic [DEN_W-1:0] div_den;
    logic             div_done;
    logic             div_ovf;
    logic [QUO_W-1:0] div_quo;

    logic               in_fire;
    logic               cfg_fire;
    logic               evt_ok;
    logic               push_done;
    logic [2:0]         pow2;
    logic [7:0]         click;
    logic [TICKS_W-1:0] ticks;
    logic [23:0]        tempo;
    logic [7:0]         on_status;
    logic [7:0]         off_status;
    evt_t               evt;

    assign in_fire  = s_valid && s_ready;
    assign cfg_fire = cfg_valid && cfg_ready;

    mte_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .ovf     (div_ovf),
        .quo     (div_quo)
    );

    // Time signature base must be a power of two from 1 to 32.
    always_comb begin
        evt_ok = 1'b1;
        pow2   = 3'd0;
        case (sig_base_reg)
            8'd1:    pow2 = 3'd0;
            8'd2:    pow2 = 3'd1;
            8'd4:    pow2 = 3'd2;
            8'd8:    pow2 = 3'd3;
            8'd16:   pow2 = 3'd4;
            8'd32:   pow2 = 3'd5;
            default: evt_ok = (op_reg != OP_TSIG);
        endcase
    end

    assign click      = (pow2 == 3'd3) ? CLICK_TRIPLE : CLICK_PLAIN;
    assign ticks      = (div_ovf || (div_quo[QUO_W-1:TICKS_W] != '0)) ?
                        MAX_TICKS : div_quo[TICKS_W-1:0];
    assign tempo      = (upq_reg > DEN_W'(MAX_TEMPO)) ? MAX_TEMPO : upq_reg[23:0];
    assign on_status  = {NIB_NOTE_ON, channel_reg};
    assign off_status = {NIB_NOTE_OFF, channel_reg};

    always_comb begin
        evt.bytes = '0;
        evt.count = '0;
        evt.bytes[0] = BYTE_ZERO;
        case (op_reg)
            OP_NOTE: begin
                evt.bytes[1] = on_status;
                evt.bytes[2] = {1'b0, key_reg};
                evt.bytes[3] = {1'b0, velocity_reg};
                if (ticks[20:14] != '0) begin
                    evt.bytes[4] = {1'b1, ticks[20:14]};
                    evt.bytes[5] = {1'b1, ticks[13:7]};
                    evt.bytes[6] = {1'b0, ticks[6:0]};
                    evt.bytes[7] = off_status;
                    evt.bytes[8] = {1'b0, key_reg};
                    evt.bytes[9] = OFF_VELOCITY;
                    evt.count    = COUNT_W'(10);
                end else if (ticks[13:7] != '0) begin
                    evt.bytes[4] = {1'b1, ticks[13:7]};
                    evt.bytes[5] = {1'b0, ticks[6:0]};
                    evt.bytes[6] = off_status;
                    evt.bytes[7] = {1'b0, key_reg};
                    evt.bytes[8] = OFF_VELOCITY;
                    evt.count    = COUNT_W'(9);
                end else begin
                    evt.bytes[4] = {1'b0, ticks[6:0]};
                    evt.bytes[5] = off_status;
                    evt.bytes[6] = {1'b0, key_reg};
                    evt.bytes[7] = OFF_VELOCITY;
                    evt.count    = COUNT_W'(8);
                end
            end
            OP_TEMPO: begin
                evt.bytes[1] = META_PREFIX;
                evt.bytes[2] = META_TEMPO;
                evt.bytes[3] = LEN_TEMPO;
                evt.bytes[4] = tempo[23:16];
                evt.bytes[5] = tempo[15:8];
                evt.bytes[6] = tempo[7:0];
                evt.count    = COUNT_W'(7);
            end
            OP_TSIG: begin
                evt.bytes[1] = META_PREFIX;
                evt.bytes[2] = META_TSIG;
                evt.bytes[3] = LEN_TSIG;
                evt.bytes[4] = sig_beats_reg;
                evt.bytes[5] = {5'b0, pow2};
                evt.bytes[6] = click;
                evt.bytes[7] = CLOCKS_32ND;
                evt.count    = COUNT_W'(8);
            end
            default: begin
                evt.bytes[1] = META_PREFIX;
                evt.bytes[2] = META_EOT;
                evt.bytes[3] = BYTE_ZERO;
                evt.count    = COUNT_W'(4);
            end
        endcase
    end

    assign q_evt     = evt;
    assign push_done = !evt_ok || q_ready;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE: begin
                if (cfg_valid) begin
                    state_next = (cfg_index == CFG_BPM) ? F_TEMPO : F_IDLE;
                end else if (s_valid) begin
                    state_next = (s_op == OP_NOTE) ? F_DSTART : F_PUSH;
                end
            end
            F_TEMPO: begin
                if (div_done) begin
                    state_next = F_IDLE;
                end
            end
            F_DSTART: state_next = F_DWAIT;
            F_DWAIT: begin
                if (div_done) begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH: begin
                if (push_done) begin
                    if (s_valid) begin
                        state_next = (s_op == OP_NOTE) ? F_DSTART : F_PUSH;
                    end else begin
                        state_next = F_IDLE;
                    end
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        s_ready   = 1'b0;
        cfg_ready = 1'b0;
        q_valid   = 1'b0;
        div_start = 1'b0;
        div_num   = prod_reg;
        div_den   = upq_reg;
        case (state_reg)
            F_IDLE: begin
                cfg_ready = 1'b1;
                s_ready   = !cfg_valid;
                if (cfg_valid && (cfg_index == CFG_BPM)) begin
                    div_start = 1'b1;
                    div_num   = NUM_W'(USEC_PER_MINUTE);
                    // A tempo of zero counts as one beat per minute.
                    div_den   = (cfg_data == '0) ? DEN_W'(1) : DEN_W'(cfg_data);
                end
            end
            F_DSTART: div_start = 1'b1;
            F_PUSH: begin
                q_valid = evt_ok;
                s_ready = push_done;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= F_IDLE;
            upq_reg       <= RESET_USEC_PER_QUARTER;
            sig_beats_reg <= RESET_SIG_BEATS;
            sig_base_reg  <= RESET_SIG_BASE;
        end else begin
            state_reg <= state_next;
            if (state_reg == F_TEMPO && div_done) begin
                upq_reg <= div_quo[DEN_W-1:0];
            end
            if (cfg_fire) begin
                case (cfg_index)
                    CFG_SIG_BEATS: sig_beats_reg <= cfg_data[7:0];
                    CFG_SIG_BASE:  sig_base_reg  <= cfg_data[7:0];
                    default:       sig_beats_reg <= sig_beats_reg;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            op_reg       <= op_t'(s_op);
            channel_reg  <= s_channel;
            key_reg      <= s_key;
            velocity_reg <= s_velocity;
            prod_reg     <= NUM_W'(TPQ) * NUM_W'(s_duration_us);
        end
    end

endmodule

@@ rtl/core/mte_queue.sv @@
// Two-entry event queue between the front end and the byte emitter.
`timescale 1ns / 1ps

module mte_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  mte_pkg::evt_t in_evt,
    output logic          out_valid,
    input  logic          out_ready,
    output mte_pkg::evt_t out_evt
);
    import mte_pkg::*;

    evt_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;
    logic       push;
    logic       pop;

    assign in_ready  = (fill_reg != 2'd2);
    assign out_valid = (fill_reg != 2'd0);
    assign out_evt   = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop) begin
                fill_reg <= fill_reg + 2'd1;
            end else if (pop && !push) begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_evt;
        end
    end

endmodule

@@ rtl/core/mte_emit.sv @@
// Back end: holds one event's bytes and sends them one word per cycle while m_ready is high.
`timescale 1ns / 1ps

module mte_emit (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          q_valid,
    output logic          q_ready,
    input  mte_pkg::evt_t q_evt,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [7:0]    m_out_byte,
    output logic          m_last
);
    import mte_pkg::*;

    logic [PENDING_DEPTH-1:0][7:0] pending_bytes_reg;
    logic [COUNT_W-1:0]            byte_count_reg;
    logic [COUNT_W-1:0]            emit_index_reg;
    logic                          active_reg;
    logic                          m_valid_reg;
    logic [7:0]                    m_out_byte_reg;
    logic                          m_last_reg;
    logic                          load;
    logic                          is_last;

    assign load    = active_reg && (!m_valid_reg || m_ready);
    assign is_last = (emit_index_reg == byte_count_reg - 1'b1);
    // The next event is taken in the same cycle its predecessor's last word
    // moves to the output register.
    assign q_ready = !active_reg || (load && is_last);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg     <= 1'b0;
            m_valid_reg    <= 1'b0;
            byte_count_reg <= '0;
            emit_index_reg <= '0;
        end else begin
            m_valid_reg <= load || (m_valid_reg && !m_ready);
            if (load) begin
                emit_index_reg <= emit_index_reg + 1'b1;
                if (is_last) begin
                    active_reg <= 1'b0;
                end
            end
            if (q_valid && q_ready) begin
                active_reg     <= 1'b1;
                byte_count_reg <= q_evt.count;
                emit_index_reg <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_valid && q_ready) begin
            pending_bytes_reg <= q_evt.bytes;
        end
        if (load) begin
            m_out_byte_reg <= pending_bytes_reg[emit_index_reg];
            m_last_reg     <= is_last;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_out_byte = m_out_byte_reg;
    assign m_last     = m_last_reg;

endmodule

@@ rtl/core/midi_track_event_encoder_unit.sv @@
// Top level of the track event encoder: front end, event queue and byte emitter.
// Notes are limited by the radix-16 tick divider in the front end, which takes no new
// event while a division runs; other events by the emitter's one byte per cycle while
// m_ready is high. A tempo register write recomputes microseconds per quarter on the
// same divider.
// Synchronous active-low reset empties the queue and restores tempo 120 and signature 4/4.
`timescale 1ns / 1ps

module midi_track_event_encoder_unit #(
    parameter int TICKS_PER_QUARTER = 240
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [1:0]                s_op,
    input  logic [3:0]                s_channel,
    input  logic [6:0]                s_key,
    input  logic [6:0]                s_velocity,
    input  logic [mte_pkg::DUR_W-1:0] s_duration_us,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [7:0]                m_out_byte,
    output logic                      m_last,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [1:0]                cfg_index,
    input  logic [9:0]                cfg_data
);
    import mte_pkg::*;

    logic fq_valid;
    logic fq_ready;
    evt_t fq_evt;
    logic qe_valid;
    logic qe_ready;
    evt_t qe_evt;

    mte_front #(
        .TICKS_PER_QUARTER (TICKS_PER_QUARTER)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_channel     (s_channel),
        .s_key         (s_key),
        .s_velocity    (s_velocity),
        .s_duration_us (s_duration_us),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .q_valid       (fq_valid),
        .q_ready       (fq_ready),
        .q_evt         (fq_evt)
    );

    mte_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_evt    (fq_evt),
        .out_valid (qe_valid),
        .out_ready (qe_ready),
        .out_evt   (qe_evt)
    );

    mte_emit u_emit (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (qe_valid),
        .q_ready    (qe_ready),
        .q_evt      (qe_evt),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_last     (m_last)
    );

endmodule
